// ----- design/route_table_best_metric_lookup_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ROUTE_TABLE_BEST_METRIC_LOOKUP_MACROS_SVH
`define ROUTE_TABLE_BEST_METRIC_LOOKUP_MACROS_SVH

// Same-cycle implication.
`define RTBL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RTBL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/rtbl_pkg.sv -----
`timescale 1ns / 1ps

package rtbl_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int PART_BITS     = 16;
   localparam int FIELD_W       = 16;
   localparam int PORT_W        = 8;
   localparam int STATUS_W      = 3;
   localparam int KEY_W         = 2 * PART_BITS;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 4;

   localparam logic [FIELD_W-1:0] UNREACH_RESET = FIELD_W'(16);

   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_LOOKUP = 1'b1
   } opcode_type;

   localparam logic [STATUS_W-1:0] STATUS_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FOUND   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOROUTE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_UNREACH = 3'd4;

   typedef struct packed {
      logic [PORT_W-1:0]  port;
      logic [KEY_W-1:0]   hop;
      logic [FIELD_W-1:0] metric;
      logic [KEY_W-1:0]   key;
   } entry_type;

   typedef struct packed {
      logic             start;
      logic [KEY_W-1:0] key_exact;
      logic [KEY_W-1:0] key_fb;
   } scan_req_type;

   typedef struct packed {
      logic      done;
      logic      found;
      logic      fallback;
      entry_type best;
   } scan_res_type;

   function automatic logic [KEY_W-1:0] make_key(input logic [FIELD_W-1:0] sub,
                                                 input logic [FIELD_W-1:0] node);
      return {PART_BITS'(sub), PART_BITS'(node)};
   endfunction

endpackage

// ----- design/rtbl_ram.sv -----
`timescale 1ns / 1ps

module rtbl_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rtbl_scan.sv -----
`timescale 1ns / 1ps

module rtbl_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  rtbl_pkg::scan_req_type       req,
   input  logic [rtbl_pkg::CNT_W-1:0]   fill,
   output logic                         ram_rd_en,
   output logic [rtbl_pkg::IDX_W-1:0]   ram_rd_addr,
   input  rtbl_pkg::entry_type          ram_rd_data,
   output rtbl_pkg::scan_res_type       res
);
   import rtbl_pkg::*;

   typedef enum logic [1:0] {
      SC_IDLE = 2'b01,
      SC_RUN  = 2'b10
   } scan_state_type;

   scan_state_type   state_ff, state_in;
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             pass_ff, pass_in;
   logic             found_ff, found_in;
   entry_type        best_ff, best_in;
   logic [KEY_W-1:0] key_exact_ff, key_exact_in;
   logic [KEY_W-1:0] key_fb_ff, key_fb_in;
   logic [KEY_W-1:0] cur_key;
   logic             more;
   logic             res_done;

   // pass 0 looks for the exact key, pass 1 for subnet with node zero
   assign cur_key = pass_ff ? key_fb_ff : key_exact_ff;
   assign more    = addr_ff < fill;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      rd_vld_in    = 1'b0;
      pass_in      = pass_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      key_exact_in = key_exact_ff;
      key_fb_in    = key_fb_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = addr_ff[IDX_W-1:0];
      res_done     = 1'b0;
      unique case (state_ff)
         SC_IDLE: begin
            if (req.start) begin
               state_in     = SC_RUN;
               addr_in      = '0;
               pass_in      = 1'b0;
               found_in     = 1'b0;
               key_exact_in = req.key_exact;
               key_fb_in    = req.key_fb;
            end
         end
         SC_RUN: begin
            if (more) begin
               ram_rd_en = 1'b1;
               addr_in   = CNT_W'(addr_ff + 1'b1);
               rd_vld_in = 1'b1;
            end
            // strict less-than keeps the earliest entry on a tie
            if (rd_vld_ff && (ram_rd_data.key == cur_key) &&
                (!found_ff || (ram_rd_data.metric < best_ff.metric))) begin
               found_in = 1'b1;
               best_in  = ram_rd_data;
            end
            if (!more && !rd_vld_ff) begin
               if (found_ff || pass_ff || (key_exact_ff == key_fb_ff)) begin
                  res_done = 1'b1;
                  state_in = SC_IDLE;
               end else begin
                  pass_in = 1'b1;
                  addr_in = '0;
               end
            end
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SC_IDLE;
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
         pass_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         rd_vld_ff <= rd_vld_in;
         pass_ff   <= pass_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      key_exact_ff <= key_exact_in;
      key_fb_ff    <= key_fb_in;
   end

   assign res.done     = res_done;
   assign res.found    = found_ff;
   assign res.fallback = pass_ff;
   assign res.best     = best_ff;

endmodule

// ----- design/route_table_best_metric_lookup.sv -----
// Add: result word registered in the cycle after the request word is taken.
// Lookup: one table entry read per cycle from a single RAM read port; the result
//   is registered when the scan ends, after the subnet-only pass if that runs.
// One request at a time; the next word is taken once the result register is free.
// Reset (synchronous): table empty, unreachable threshold 16; RAM contents kept.
`timescale 1ns / 1ps

module route_table_best_metric_lookup (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rtbl_pkg::FIELD_W-1:0]      csr_wr_data,  // unreachable_metric
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // dst_subnet, dst_node, new_metric, hop_subnet, hop_node, port_id
   input  logic [rtbl_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [rtbl_pkg::REQ_USER_W-1:0]   req_tuser,    // opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_port, out_metric, out_hop_subnet, out_hop_node
   output logic [rtbl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [rtbl_pkg::RSP_USER_W-1:0]   rsp_tuser     // status, used_fallback
);
   import rtbl_pkg::*;

   typedef enum logic [1:0] {
      TOP_IDLE = 2'b01,
      TOP_SCAN = 2'b10
   } top_state_type;

   top_state_type           state_ff, state_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [FIELD_W-1:0]      thresh_ff, thresh_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]   rsp_user_ff, rsp_user_in;

   opcode_type         opcode;
   logic [FIELD_W-1:0] dst_subnet, dst_node, new_metric, hop_subnet, hop_node;
   logic [PORT_W-1:0]  port_id;
   logic               accept, table_full, wr_en;
   entry_type          wr_entry, rd_entry;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   scan_req_type       scan_req;
   scan_res_type       scan_res;
   logic [STATUS_W-1:0] lk_status;

   assign opcode     = opcode_type'(req_tuser[0]);
   assign dst_subnet = req_tdata[15:0];
   assign dst_node   = req_tdata[31:16];
   assign new_metric = req_tdata[47:32];
   assign hop_subnet = req_tdata[63:48];
   assign hop_node   = req_tdata[79:64];
   assign port_id    = req_tdata[87:80];

   assign req_tready = (state_ff == TOP_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign table_full = fill_ff == CNT_W'(TABLE_ENTRIES);
   assign wr_en      = accept && (opcode == OP_ADD) && !table_full;

   assign wr_entry.key    = make_key(dst_subnet, dst_node);
   assign wr_entry.metric = new_metric;
   assign wr_entry.hop    = make_key(hop_subnet, hop_node);
   assign wr_entry.port   = port_id;

   assign scan_req.start     = accept && (opcode == OP_LOOKUP);
   assign scan_req.key_exact = make_key(dst_subnet, dst_node);
   assign scan_req.key_fb    = make_key(dst_subnet, '0);

   rtbl_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_entry)
   );

   rtbl_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .req         (scan_req),
      .fill        (fill_ff),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (rd_entry),
      .res         (scan_res)
   );

   assign lk_status = (scan_res.best.metric >= thresh_ff) ? STATUS_UNREACH : STATUS_FOUND;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      thresh_in    = csr_wr_en ? csr_wr_data : thresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (wr_en) begin
         fill_in = CNT_W'(fill_ff + 1'b1);
      end
      unique case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               if (opcode == OP_ADD) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_user_in  = {1'b0, table_full ? STATUS_FULL : STATUS_ADDED};
               end else begin
                  state_in = TOP_SCAN;
               end
            end
         end
         TOP_SCAN: begin
            if (scan_res.done) begin
               state_in     = TOP_IDLE;
               rsp_valid_in = 1'b1;
               if (scan_res.found) begin
                  rsp_data_in = {FIELD_W'(scan_res.best.hop[PART_BITS-1:0]),
                                 FIELD_W'(scan_res.best.hop[KEY_W-1:PART_BITS]),
                                 scan_res.best.metric,
                                 scan_res.best.port};
                  rsp_user_in = {scan_res.fallback, lk_status};
               end else begin
                  rsp_data_in = '0;
                  rsp_user_in = {1'b0, STATUS_NOROUTE};
               end
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         fill_ff      <= '0;
         thresh_ff    <= UNREACH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- design/rtbl_checker.sv -----
`timescale 1ns / 1ps
`include "route_table_best_metric_lookup_macros.svh"

module rtbl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [rtbl_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rtbl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [rtbl_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import rtbl_pkg::*;

   logic req_take, rsp_stall;

   assign req_take  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `RTBL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid, "rsp word dropped")
   `RTBL_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall,
      $stable(rsp_tdata) && $stable(rsp_tuser), "rsp word changed while stalled")
   // an add answers in the next cycle with added or full and an empty payload
   `RTBL_ASSERT_NEXT(a_add_rsp, clock, reset, req_take && (req_tuser[0] == OP_ADD),
      rsp_tvalid && (rsp_tdata == '0) && (rsp_tuser[3] == 1'b0) &&
      ((rsp_tuser[2:0] == STATUS_ADDED) || (rsp_tuser[2:0] == STATUS_FULL)),
      "add result missing or malformed")
   // a lookup holds off the next word as the table scan begins
   `RTBL_ASSERT_NEXT(a_lookup_gap, clock, reset, req_take && (req_tuser[0] == OP_LOOKUP),
      !req_tready, "next word taken during a lookup")

endmodule

bind route_table_best_metric_lookup rtbl_checker u_rtbl_checker (.*);
